FILE: design/prl_pkg.sv
// prl_pkg: field widths, operation and status codes, and the command
// record passed from the front end to the back end of the record list.
// No dependencies.
package prl_pkg;

  localparam int OpWidth     = 2;
  localparam int PosWidth    = 9;
  localparam int IdWidth     = 20;
  localparam int SexWidth    = 8;
  localparam int ScoreWidth  = 16;
  localparam int StatusWidth = 2;
  localparam int CountWidth  = 9;

  // operation codes
  localparam logic [OpWidth-1:0] OP_INSERT = 2'd0;
  localparam logic [OpWidth-1:0] OP_DELETE = 2'd1;
  localparam logic [OpWidth-1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [StatusWidth-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusWidth-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

  // what the back end has to do with a command
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_INS  = 2'd1,
    K_DEL  = 2'd2,
    K_QRY  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [IdWidth-1:0]    id;
    logic [SexWidth-1:0]   sex;
    logic [ScoreWidth-1:0] score;
  } record_t;

  typedef struct packed {
    kind_e                  kind;
    logic [StatusWidth-1:0] status;
    record_t                rec;
    logic [CountWidth-1:0]  count;   // entry count after this command
  } cmd_t;

endpackage

FILE: design/prl_ram.sv
// prl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/prl_fifo.sv
// prl_fifo: small register queue between front end and back end.
// No dependencies. DEPTH must be at least 2.
module prl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: design/prl_front.sv
// prl_front: accepts operations, tracks the record count and classifies
// each operation into a command for the back end. Depends on prl_pkg.
module prl_front #(
  parameter int CAPACITY = 256,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [prl_pkg::OpWidth-1:0]       opcode_i,
  input  logic [prl_pkg::PosWidth-1:0]      position_i,
  input  logic [prl_pkg::IdWidth-1:0]       record_id_i,
  input  logic [prl_pkg::SexWidth-1:0]      record_sex_i,
  input  logic [prl_pkg::ScoreWidth-1:0]    record_score_i,
  input  logic                              full_i,
  output logic                              push_o,
  output prl_pkg::cmd_t                     cmd_o,
  output logic [CW-1:0]                     rem_o,
  output logic [AW-1:0]                     start_o,
  output logic [AW-1:0]                     addr_o
);
  import prl_pkg::*;

  localparam int PW = (CW > PosWidth) ? CW : PosWidth;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] cnt_ext, pos_ext, after_ext;
  kind_e         kind;
  logic [StatusWidth-1:0] status;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign cnt_ext    = PW'(count_q);
  assign pos_ext    = PW'(position_i);

  always_comb begin
    kind    = K_NONE;
    status  = ST_DONE;
    count_d = count_q;
    case (opcode_i)
      OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (count_q == CapCnt) begin
          status = ST_FULL;
        end else begin
          kind    = K_INS;
          count_d = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          kind    = K_DEL;
          count_d = count_q - 1'b1;
        end
      end
      OP_QUERY: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          kind = K_QRY;
        end
      end
      default: begin
      end
    endcase
  end

  assign after_ext = PW'(count_d);

  always_comb begin
    cmd_o.kind      = kind;
    cmd_o.status    = status;
    cmd_o.rec.id    = record_id_i;
    cmd_o.rec.sex   = record_sex_i;
    cmd_o.rec.score = record_score_i;
    cmd_o.count     = after_ext[CountWidth-1:0];
  end

  // records to move: count - position, for both insert and delete
  assign rem_o   = CW'(cnt_ext - pos_ext);
  assign start_o = (opcode_i == OP_INSERT) ? AW'(cnt_ext - PW'(1)) : AW'(pos_ext);
  assign addr_o  = (opcode_i == OP_INSERT) ? AW'(pos_ext) : AW'(pos_ext - PW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("record count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && kind == K_INS) |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

endmodule

FILE: design/prl_back.sv
// prl_back: carries out commands on the record RAM (one record moved per
// cycle on insert and delete) and holds the result register.
// Depends on prl_pkg and prl_ram.
module prl_back #(
  parameter int CAPACITY = 256,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  output logic                              pop_o,
  input  prl_pkg::cmd_t                     cmd_i,
  input  logic [CW-1:0]                     rem_i,
  input  logic [AW-1:0]                     start_i,
  input  logic [AW-1:0]                     addr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [prl_pkg::StatusWidth-1:0]   status_o,
  output logic [prl_pkg::IdWidth-1:0]       found_id_o,
  output logic [prl_pkg::SexWidth-1:0]      found_sex_o,
  output logic [prl_pkg::ScoreWidth-1:0]    found_score_o,
  output logic [prl_pkg::CountWidth-1:0]    entry_count_o
);
  import prl_pkg::*;

  localparam int RW = $bits(record_t);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MOVE = 5'b00010,
    B_PUT  = 5'b00100,
    B_QRD  = 5'b01000,
    B_FIN  = 5'b10000
  } bst_e;

  bst_e          state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [AW-1:0] rd_q, rd_d, wa_q, wa_d, addr_q, addr_d;
  logic          pend_q, pend_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  record_t       rd_rec;

  logic                   out_valid_q, out_valid_d, out_load, out_free;
  logic [StatusWidth-1:0] status_q;
  record_t                found_q;
  logic [CountWidth-1:0]  count_q;

  prl_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_rec   = record_t'(rdata);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    rem_d    = rem_q;
    rd_d     = rd_q;
    wa_d     = wa_q;
    addr_d   = addr_q;
    pend_d   = 1'b0;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = wa_q;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = rd_q;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = cmd_i;
          rem_d  = rem_i;
          rd_d   = start_i;
          addr_d = addr_i;
          case (cmd_i.kind)
            K_INS, K_DEL: state_d = B_MOVE;
            K_QRY:        state_d = B_QRD;
            default:      state_d = B_FIN;
          endcase
        end
      end
      B_MOVE: begin
        // write back the record read last cycle, read the next one
        we = pend_q;
        if (rem_q != '0) begin
          re     = 1'b1;
          pend_d = 1'b1;
          rem_d  = rem_q - 1'b1;
          if (cmd_q.kind == K_INS) begin
            rd_d = rd_q - 1'b1;
            wa_d = rd_q + 1'b1;
          end else begin
            rd_d = rd_q + 1'b1;
            wa_d = rd_q - 1'b1;
          end
        end else begin
          // last write-back (if any) goes out this cycle
          state_d = (cmd_q.kind == K_INS) ? B_PUT : B_FIN;
        end
      end
      B_PUT: begin
        we      = 1'b1;
        waddr   = addr_q;
        wdata   = cmd_q.rec;
        state_d = B_FIN;
      end
      B_QRD: begin
        re      = 1'b1;
        raddr   = addr_q;
        state_d = B_FIN;
      end
      B_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    rem_q  <= rem_d;
    rd_q   <= rd_d;
    wa_q   <= wa_d;
    addr_q <= addr_d;
    if (out_load) begin
      status_q <= cmd_q.status;
      count_q  <= cmd_q.count;
      found_q  <= (cmd_q.kind == K_QRY) ? rd_rec : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_id_o    = found_q.id;
  assign found_sex_o   = found_q.sex;
  assign found_score_o = found_q.score;
  assign entry_count_o = count_q;

  a_pend_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == B_MOVE)
    else $error("pending write outside a move");

  a_move_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_MOVE |-> (cmd_q.kind == K_INS || cmd_q.kind == K_DEL))
    else $error("move sequence for a command that moves nothing");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_FIN && out_valid_q && !out_ready_i) |=> state_q == B_FIN)
    else $error("result dropped while output register busy");

endmodule

FILE: design/positional_record_list_top.sv
// positional_record_list_top: ordered record list with insert, delete and
// query by position. Depends on prl_pkg, prl_front, prl_fifo and prl_back.
//
// Usage: every transfer on the input channel returns exactly one result
// transfer, in order. The front end checks the position against the record
// count it keeps, settles status and the new entry_count at once, and
// queues a command; it takes a new transfer every cycle while the command
// queue (QUEUE_DEPTH entries) has room. The back end works the record RAM,
// which has one write and one read port, so an insert or delete moves one
// record per cycle: with n records held and position p, an insert shifts
// n - p records up and writes the new record, a delete shifts n - p
// records down, a query reads one, and a failed or unused-opcode operation
// touches no record. Found fields are zero except on a successful query.
// The RAM is not cleared at reset; only entries written by an insert are
// ever read. The result register lets a finished result wait for
// out_ready_i while the back end takes the next command up to its last step.
module positional_record_list_top #(
  parameter int CAPACITY    = 256,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [prl_pkg::OpWidth-1:0]       opcode_i,
  input  logic [prl_pkg::PosWidth-1:0]      position_i,
  input  logic [prl_pkg::IdWidth-1:0]       record_id_i,
  input  logic [prl_pkg::SexWidth-1:0]      record_sex_i,
  input  logic [prl_pkg::ScoreWidth-1:0]    record_score_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [prl_pkg::StatusWidth-1:0]   status_o,
  output logic [prl_pkg::IdWidth-1:0]       found_id_o,
  output logic [prl_pkg::SexWidth-1:0]      found_sex_o,
  output logic [prl_pkg::ScoreWidth-1:0]    found_score_o,
  output logic [prl_pkg::CountWidth-1:0]    entry_count_o
);
  import prl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // record count width
  localparam int AW = $clog2(CAPACITY);       // RAM address width
  localparam int QW = $bits(cmd_t) + CW + 2 * AW;

  // front end -> queue
  logic          push, full;
  cmd_t          f_cmd;
  logic [CW-1:0] f_rem;
  logic [AW-1:0] f_start, f_addr;

  // queue -> back end
  logic          pop, empty;
  logic [QW-1:0] q_data;
  cmd_t          b_cmd;
  logic [CW-1:0] b_rem;
  logic [AW-1:0] b_start, b_addr;

  prl_front #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .AW       (AW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .record_id_i    (record_id_i),
    .record_sex_i   (record_sex_i),
    .record_score_i (record_score_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (f_cmd),
    .rem_o          (f_rem),
    .start_o        (f_start),
    .addr_o         (f_addr)
  );

  prl_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_rem, f_start, f_addr}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_data),
    .empty_o (empty)
  );

  assign {b_cmd, b_rem, b_start, b_addr} = q_data;

  prl_back #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .AW       (AW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .cmd_i         (b_cmd),
    .rem_i         (b_rem),
    .start_i       (b_start),
    .addr_i        (b_addr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_id_o    (found_id_o),
    .found_sex_o   (found_sex_o),
    .found_score_o (found_score_o),
    .entry_count_o (entry_count_o)
  );

endmodule
